// ===== hdl/cbr_pkg.sv =====
// Shared types and constants of the 3x3 convolution / bias / ReLU unit.
// No dependencies; cbr_cfg_regs, cbr_datapath, cbr_ctrl and the top level import this package.
package cbr_pkg;

  // Default store geometry, handed to the top-level parameters
  localparam int MAX_HEIGHT_DEF      = 32;
  localparam int MAX_WIDTH_DEF       = 32;
  localparam int MAX_IN_CHANNELS_DEF = 64;
  localparam int MAX_FILTERS_DEF     = 64;

  // Fixed-point format
  localparam int DATA_W    = 16;   // width of a stored pixel, weight or bias
  localparam int DATA_BITS = 16;   // saturation width of the activation
  localparam int FRAC_BITS = 8;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int ACT_W     = 15;
  localparam int ACT_LIMIT_RAW = (1 << (DATA_BITS - 1)) - 1;
  localparam int ACT_LIMIT = (ACT_LIMIT_RAW > 32767) ? 32767 : ACT_LIMIT_RAW;

  localparam int KERNEL   = 3;
  localparam logic [1:0] TAP_LAST = 2'd2;

  // Item command codes
  localparam logic [1:0] CMD_PIXEL   = 2'd0;
  localparam logic [1:0] CMD_WEIGHT  = 2'd1;
  localparam logic [1:0] CMD_BIAS    = 2'd2;
  localparam logic [1:0] CMD_COMPUTE = 2'd3;

  // Configuration registers
  localparam int CFG_AW = 4;
  localparam logic [1:0] REG_HEIGHT   = 2'd0;
  localparam logic [1:0] REG_WIDTH    = 2'd1;
  localparam logic [1:0] REG_CHANNELS = 2'd2;
  localparam logic [1:0] REG_FILTERS  = 2'd3;
  localparam logic [5:0] HEIGHT_RST   = 6'd24;
  localparam logic [5:0] WIDTH_RST    = 6'd24;
  localparam logic [6:0] CHANNELS_RST = 7'd3;
  localparam logic [6:0] FILTERS_RST  = 7'd64;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [4:0]        row;
    logic [4:0]        col;
    logic [5:0]        in_channel;
    logic [5:0]        filter;
    logic [1:0]        tap_row;
    logic [1:0]        tap_col;
    logic signed [15:0] data_value;
  } cbr_item_t;

  typedef struct packed {
    logic [4:0]  out_row;
    logic [4:0]  out_col;
    logic [5:0]  out_filter;
    logic [14:0] activation;
  } cbr_result_t;

  // Effective (clamped) configuration
  typedef struct packed {
    logic [5:0] h;
    logic [5:0] w;
    logic [6:0] nc;
    logic [6:0] nf;
  } cbr_cfg_t;

  // Controller to datapath
  typedef struct packed {
    logic       load;       // store the current item
    logic       req_load;   // capture a compute request
    logic       bias_rd;    // read the bias of the captured filter
    logic       tap_issue;  // read one pixel/weight pair
    logic [1:0] kr;
    logic [1:0] kc;
    logic [6:0] ch;
    logic       finish;     // accumulator complete, emit result
  } cbr_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic req_ok;     // compute request lies inside the configured shape
    logic pipe_busy;  // products still in flight
  } cbr_status_t;

endpackage

// ===== hdl/cbr_ram.sv =====
// Generic single-port RAM with registered read, no reset on contents.
// No dependencies.
module cbr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/cbr_cfg_regs.sv =====
// APB-style configuration registers and their clamped effective values.
// Depends on cbr_pkg.
module cbr_cfg_regs #(
  parameter int MAX_HEIGHT      = cbr_pkg::MAX_HEIGHT_DEF,
  parameter int MAX_WIDTH       = cbr_pkg::MAX_WIDTH_DEF,
  parameter int MAX_IN_CHANNELS = cbr_pkg::MAX_IN_CHANNELS_DEF,
  parameter int MAX_FILTERS     = cbr_pkg::MAX_FILTERS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel_i,
  input  logic                      penable_i,
  input  logic                      pwrite_i,
  input  logic [cbr_pkg::CFG_AW-1:0] paddr_i,
  input  logic [31:0]               pwdata_i,
  output logic [31:0]               prdata_o,
  output cbr_pkg::cbr_cfg_t         cfg_o
);
  import cbr_pkg::*;

  logic [5:0] height_q, width_q;
  logic [6:0] channels_q, filters_q;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign wr_en   = psel_i && penable_i && pwrite_i;
  assign reg_idx = paddr_i[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      height_q   <= HEIGHT_RST;
      width_q    <= WIDTH_RST;
      channels_q <= CHANNELS_RST;
      filters_q  <= FILTERS_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_HEIGHT:   height_q   <= pwdata_i[5:0];
        REG_WIDTH:    width_q    <= pwdata_i[5:0];
        REG_CHANNELS: channels_q <= pwdata_i[6:0];
        REG_FILTERS:  filters_q  <= pwdata_i[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_HEIGHT:   prdata_o = {26'd0, height_q};
      REG_WIDTH:    prdata_o = {26'd0, width_q};
      REG_CHANNELS: prdata_o = {25'd0, channels_q};
      REG_FILTERS:  prdata_o = {25'd0, filters_q};
      default:      prdata_o = '0;
    endcase
  end

  // zero reads as one, anything above the store size as the store size
  always_comb begin
    cfg_o.h  = (height_q == '0) ? 6'd1 :
               ((int'(height_q) > MAX_HEIGHT) ? 6'(MAX_HEIGHT) : height_q);
    cfg_o.w  = (width_q == '0) ? 6'd1 :
               ((int'(width_q) > MAX_WIDTH) ? 6'(MAX_WIDTH) : width_q);
    cfg_o.nc = (channels_q == '0) ? 7'd1 :
               ((int'(channels_q) > MAX_IN_CHANNELS) ? 7'(MAX_IN_CHANNELS) : channels_q);
    cfg_o.nf = (filters_q == '0) ? 7'd1 :
               ((int'(filters_q) > MAX_FILTERS) ? 7'(MAX_FILTERS) : filters_q);
  end

endmodule

// ===== hdl/cbr_datapath.sv =====
// Datapath: pixel, weight and bias stores, tap addressing, one multiplier,
// accumulator, ReLU/shift/saturate and the result register.
// Depends on cbr_pkg and cbr_ram.
module cbr_datapath #(
  parameter int MAX_HEIGHT      = cbr_pkg::MAX_HEIGHT_DEF,
  parameter int MAX_WIDTH       = cbr_pkg::MAX_WIDTH_DEF,
  parameter int MAX_IN_CHANNELS = cbr_pkg::MAX_IN_CHANNELS_DEF,
  parameter int MAX_FILTERS     = cbr_pkg::MAX_FILTERS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cbr_pkg::cbr_item_t   item_i,
  input  cbr_pkg::cbr_cfg_t    cfg_i,
  input  cbr_pkg::cbr_cmd_t    cmd_i,
  output cbr_pkg::cbr_status_t status_o,
  output logic                 result_valid_o,
  output cbr_pkg::cbr_result_t result_o
);
  import cbr_pkg::*;

  localparam int PIX_DEPTH = MAX_HEIGHT * MAX_WIDTH * MAX_IN_CHANNELS;
  localparam int WGT_DEPTH = KERNEL * KERNEL * MAX_IN_CHANNELS * MAX_FILTERS;
  localparam int PIX_AW  = (PIX_DEPTH > 1) ? $clog2(PIX_DEPTH) : 1;
  localparam int WGT_AW  = (WGT_DEPTH > 1) ? $clog2(WGT_DEPTH) : 1;
  localparam int BIAS_AW = (MAX_FILTERS > 1) ? $clog2(MAX_FILTERS) : 1;
  localparam int ACC_W   = PROD_W + $clog2(KERNEL * KERNEL * MAX_IN_CHANNELS + 1) + 1;

  // request
  logic [4:0] row_q, col_q;
  logic [5:0] flt_q;

  // tap position
  logic signed [6:0] r_s, q_s;
  logic              in_img;

  logic pix_ok, wgt_ok, bias_ok;
  logic pix_we, wgt_we, bias_we;
  logic [PIX_AW-1:0]  pix_addr;
  logic [WGT_AW-1:0]  wgt_addr;
  logic [BIAS_AW-1:0] bias_addr;
  logic [DATA_W-1:0]  pix_rd, wgt_rd, bias_rd;

  logic s1_tap_q, s1_bias_q, s2_tap_q, s2_bias_q;
  logic signed [PROD_W-1:0] mul, prod_d, prod_q;
  logic signed [ACC_W-1:0]  acc_q, acc_shift;
  logic [ACT_W-1:0]         act;

  logic        result_valid_q;
  cbr_result_t result_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.req_load) begin
      row_q <= item_i.row;
      col_q <= item_i.col;
      flt_q <= item_i.filter;
    end
  end

  assign r_s = $signed(7'(row_q) + 7'(cmd_i.kr) - 7'd1);
  assign q_s = $signed(7'(col_q) + 7'(cmd_i.kc) - 7'd1);
  assign in_img = !r_s[6] && (r_s[5:0] < cfg_i.h) && !q_s[6] && (q_s[5:0] < cfg_i.w);

  assign pix_ok  = (int'(item_i.row) < MAX_HEIGHT) && (int'(item_i.col) < MAX_WIDTH) &&
                   (int'(item_i.in_channel) < MAX_IN_CHANNELS);
  assign wgt_ok  = (int'(item_i.tap_row) < KERNEL) && (int'(item_i.tap_col) < KERNEL) &&
                   (int'(item_i.in_channel) < MAX_IN_CHANNELS) &&
                   (int'(item_i.filter) < MAX_FILTERS);
  assign bias_ok = int'(item_i.filter) < MAX_FILTERS;

  assign pix_we  = cmd_i.load && (item_i.cmd == CMD_PIXEL) && pix_ok;
  assign wgt_we  = cmd_i.load && (item_i.cmd == CMD_WEIGHT) && wgt_ok;
  assign bias_we = cmd_i.load && (item_i.cmd == CMD_BIAS) && bias_ok;

  // loads only happen while idle, reads only while busy: one port suffices
  always_comb begin
    if (cmd_i.load) begin
      pix_addr  = PIX_AW'((int'(item_i.row) * MAX_WIDTH + int'(item_i.col)) *
                          MAX_IN_CHANNELS + int'(item_i.in_channel));
      wgt_addr  = WGT_AW'(((int'(item_i.tap_row) * KERNEL + int'(item_i.tap_col)) *
                           MAX_IN_CHANNELS + int'(item_i.in_channel)) * MAX_FILTERS +
                          int'(item_i.filter));
      bias_addr = BIAS_AW'(item_i.filter);
    end else begin
      pix_addr  = PIX_AW'((int'(r_s[5:0]) * MAX_WIDTH + int'(q_s[5:0])) *
                          MAX_IN_CHANNELS + int'(cmd_i.ch));
      wgt_addr  = WGT_AW'(((int'(cmd_i.kr) * KERNEL + int'(cmd_i.kc)) *
                           MAX_IN_CHANNELS + int'(cmd_i.ch)) * MAX_FILTERS + int'(flt_q));
      bias_addr = BIAS_AW'(flt_q);
    end
  end

  cbr_ram #(.WIDTH(DATA_W), .DEPTH(PIX_DEPTH)) u_pix_ram (
    .clk_i   (clk_i),
    .we_i    (pix_we),
    .addr_i  (pix_addr),
    .wdata_i (item_i.data_value),
    .rdata_o (pix_rd)
  );

  cbr_ram #(.WIDTH(DATA_W), .DEPTH(WGT_DEPTH)) u_wgt_ram (
    .clk_i   (clk_i),
    .we_i    (wgt_we),
    .addr_i  (wgt_addr),
    .wdata_i (item_i.data_value),
    .rdata_o (wgt_rd)
  );

  cbr_ram #(.WIDTH(DATA_W), .DEPTH(MAX_FILTERS)) u_bias_ram (
    .clk_i   (clk_i),
    .we_i    (bias_we),
    .addr_i  (bias_addr),
    .wdata_i (item_i.data_value),
    .rdata_o (bias_rd)
  );

  // pipeline: issue -> RAM data -> product -> accumulate
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_tap_q  <= 1'b0;
      s1_bias_q <= 1'b0;
      s2_tap_q  <= 1'b0;
      s2_bias_q <= 1'b0;
    end else begin
      s1_tap_q  <= cmd_i.tap_issue && in_img;
      s1_bias_q <= cmd_i.bias_rd;
      s2_tap_q  <= s1_tap_q;
      s2_bias_q <= s1_bias_q;
    end
  end

  assign mul = $signed(pix_rd) * $signed(wgt_rd);

  // bias enters as a product aligned to Q.2*FRAC_BITS
  always_comb begin
    if (s1_bias_q) begin
      prod_d = $signed({{(PROD_W - DATA_W){bias_rd[DATA_W-1]}}, bias_rd}) <<< FRAC_BITS;
    end else begin
      prod_d = mul;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (s2_bias_q) begin
      acc_q <= {{(ACC_W - PROD_W){prod_q[PROD_W-1]}}, prod_q};
    end else if (s2_tap_q) begin
      acc_q <= acc_q + {{(ACC_W - PROD_W){prod_q[PROD_W-1]}}, prod_q};
    end
  end

  assign status_o.pipe_busy = s1_tap_q || s1_bias_q || s2_tap_q || s2_bias_q;
  assign status_o.req_ok = ({1'b0, item_i.row} < cfg_i.h) && ({1'b0, item_i.col} < cfg_i.w) &&
                           ({1'b0, item_i.filter} < cfg_i.nf);

  // ReLU, truncating shift, saturate
  assign acc_shift = acc_q >>> FRAC_BITS;
  always_comb begin
    if (acc_q[ACC_W-1]) begin
      act = '0;
    end else if ($unsigned(acc_shift) > ACC_W'(ACT_LIMIT)) begin
      act = ACT_W'(ACT_LIMIT);
    end else begin
      act = acc_shift[ACT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_q <= 1'b0;
    end else begin
      result_valid_q <= cmd_i.finish;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      result_q.out_row    <= row_q;
      result_q.out_col    <= col_q;
      result_q.out_filter <= flt_q;
      result_q.activation <= act;
    end
  end

  assign result_valid_o = result_valid_q;
  assign result_o       = result_q;

endmodule

// ===== hdl/cbr_ctrl.sv =====
// Controller: accepts items, sequences bias read, channel/tap loop,
// pipeline drain and result emission. Depends on cbr_pkg.
module cbr_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [1:0]           item_cmd_i,
  input  logic [6:0]           nc_i,
  input  cbr_pkg::cbr_status_t status_i,
  output logic                 busy_o,
  output cbr_pkg::cbr_cmd_t    cmd_o
);
  import cbr_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_BIAS   = 5'b00010,
    ST_RUN    = 5'b00100,
    ST_DRAIN  = 5'b01000,
    ST_FINISH = 5'b10000
  } state_e;

  state_e     state_q, state_d;
  logic [1:0] kr_q, kr_d, kc_q, kc_d;
  logic [6:0] c_q, c_d;
  logic       accept;

  assign accept = start_i && (state_q == ST_IDLE);
  assign busy_o = (state_q != ST_IDLE);

  always_comb begin
    state_d = state_q;
    kr_d    = kr_q;
    kc_d    = kc_q;
    c_d     = c_q;
    cmd_o   = '0;
    cmd_o.kr = kr_q;
    cmd_o.kc = kc_q;
    cmd_o.ch = c_q;
    case (state_q)
      ST_IDLE: begin
        cmd_o.load     = accept && (item_cmd_i != CMD_COMPUTE);
        cmd_o.req_load = accept && (item_cmd_i == CMD_COMPUTE) && status_i.req_ok;
        if (cmd_o.req_load) begin
          kr_d    = '0;
          kc_d    = '0;
          c_d     = '0;
          state_d = ST_BIAS;
        end
      end
      ST_BIAS: begin
        cmd_o.bias_rd = 1'b1;
        state_d       = ST_RUN;
      end
      ST_RUN: begin
        cmd_o.tap_issue = 1'b1;
        if (kc_q != TAP_LAST) begin
          kc_d = kc_q + 2'd1;
        end else begin
          kc_d = '0;
          if (kr_q != TAP_LAST) begin
            kr_d = kr_q + 2'd1;
          end else begin
            kr_d = '0;
            c_d  = c_q + 7'd1;
            if (c_q == nc_i - 7'd1) begin
              state_d = ST_DRAIN;
            end
          end
        end
      end
      ST_DRAIN: begin
        if (!status_i.pipe_busy) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        cmd_o.finish = 1'b1;
        state_d      = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      kr_q    <= '0;
      kc_q    <= '0;
      c_q     <= '0;
    end else begin
      state_q <= state_d;
      kr_q    <= kr_d;
      kc_q    <= kc_d;
      c_q     <= c_d;
    end
  end

  a_finish_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINISH) |-> !status_i.pipe_busy)
    else $error("result emitted with products in flight");

  a_ch_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (c_q < nc_i))
    else $error("channel counter past configured count");

  a_busy_from_compute: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_o) |-> $past(start_i && (item_cmd_i == CMD_COMPUTE)))
    else $error("busy without an accepted compute request");

  a_bias_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.bias_rd |=> cmd_o.tap_issue)
    else $error("tap loop does not follow bias read");

endmodule

// ===== hdl/conv3x3_bias_relu_unit.sv =====
// Top level of the 3x3 same-padded convolution with bias and ReLU.
// Depends on cbr_pkg, cbr_cfg_regs, cbr_ctrl, cbr_datapath, cbr_ram.
//
// Usage:
//   Items enter on item_i, taken at a clock edge with start high and busy low.
//   Pixel, weight and bias loads write their store in that same beat and
//   leave busy low, so loads can stream one per cycle.
//   A compute request (cmd 3) inside the configured shape raises busy for
//   one bias read, one pixel/weight product per cycle through a single
//   multiplier over all channels and taps, the pipeline drain and one
//   finish state. The result beat appears on result_o with result_valid_o
//   high for exactly one cycle, in the cycle right after busy falls; a new
//   item may be accepted in it.
//   Requests outside the configured shape are dropped without a beat.
//   The receiver cannot stall; every result beat is taken when shown.
//   Configuration: APB-style, registers at byte addresses 0, 4, 8, 12
//   (height, width, input channels, filters); write only while idle.
//   Reset: control returns to idle and registers to 24, 24, 3, 64; the
//   stores are not cleared and hold nothing meaningful until written.
module conv3x3_bias_relu_unit #(
  parameter int MAX_HEIGHT      = cbr_pkg::MAX_HEIGHT_DEF,
  parameter int MAX_WIDTH       = cbr_pkg::MAX_WIDTH_DEF,
  parameter int MAX_IN_CHANNELS = cbr_pkg::MAX_IN_CHANNELS_DEF,
  parameter int MAX_FILTERS     = cbr_pkg::MAX_FILTERS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  cbr_pkg::cbr_item_t         item_i,
  output logic                       result_valid_o,
  output cbr_pkg::cbr_result_t       result_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [cbr_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import cbr_pkg::*;

  cbr_cfg_t    cfg;
  cbr_cmd_t    cmd;
  cbr_status_t status;

  assign pready = 1'b1;

  cbr_cfg_regs #(
    .MAX_HEIGHT      (MAX_HEIGHT),
    .MAX_WIDTH       (MAX_WIDTH),
    .MAX_IN_CHANNELS (MAX_IN_CHANNELS),
    .MAX_FILTERS     (MAX_FILTERS)
  ) u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .cfg_o     (cfg)
  );

  cbr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .item_cmd_i (item_i.cmd),
    .nc_i       (cfg.nc),
    .status_i   (status),
    .busy_o     (busy),
    .cmd_o      (cmd)
  );

  cbr_datapath #(
    .MAX_HEIGHT      (MAX_HEIGHT),
    .MAX_WIDTH       (MAX_WIDTH),
    .MAX_IN_CHANNELS (MAX_IN_CHANNELS),
    .MAX_FILTERS     (MAX_FILTERS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_i         (item_i),
    .cfg_i          (cfg),
    .cmd_i          (cmd),
    .status_o       (status),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule
